FILE: hdl/bqd_pkg.sv
`default_nettype none

package bqd_pkg;

    localparam int STATE_W   = 64;
    localparam int STEP_W    = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};

    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } t_coef_sel;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_WAIT_IN,
        COND_JUMP_OUT_FREE
    } t_cond;

    typedef enum logic {
        MSRC_X,
        MSRC_Y
    } t_mul_src;

    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_LOAD_P,
        ALU_ADD_P_D1,
        ALU_ADD_RND,
        ALU_FORM_Y,
        ALU_SUB_P,
        ALU_ADD_D2
    } t_alu_op;

    typedef struct packed {
        t_cond     cond;
        t_step     target;
        logic      mul_en;
        t_coef_sel mul_coef;
        t_mul_src  mul_src;
        t_alu_op   alu_op;
        logic      ld_x;
        logic      wr_d1;
        logic      wr_d2;
        logic      ld_out;
    } t_ctrl;

    localparam t_ctrl CTRL_NOP = '{
        cond:     COND_NEXT,
        target:   '0,
        mul_en:   1'b0,
        mul_coef: COEF_B0,
        mul_src:  MSRC_X,
        alu_op:   ALU_NOP,
        ld_x:     1'b0,
        wr_d1:    1'b0,
        wr_d2:    1'b0,
        ld_out:   1'b0
    };

    localparam t_step STEP_IDLE = t_step'(0);

    // Microprogram. Step 0 waits for a sample, the last step hands the result
    // to the output register and jumps back to step 0.
    function automatic t_ctrl prog_rom(input t_step step);
        t_ctrl w;
        w = CTRL_NOP;
        case (step)
            4'd0: begin
                w.cond = COND_WAIT_IN;
                w.ld_x = 1'b1;
            end
            4'd1: begin
                w.mul_en   = 1'b1;
                w.mul_coef = COEF_B0;
                w.mul_src  = MSRC_X;
            end
            4'd2: begin
                w.alu_op = ALU_ADD_P_D1;
            end
            4'd3: begin
                w.alu_op = ALU_ADD_RND;
            end
            4'd4: begin
                w.alu_op   = ALU_FORM_Y;
                w.mul_en   = 1'b1;
                w.mul_coef = COEF_B1;
                w.mul_src  = MSRC_X;
            end
            4'd5: begin
                w.alu_op   = ALU_LOAD_P;
                w.mul_en   = 1'b1;
                w.mul_coef = COEF_A1;
                w.mul_src  = MSRC_Y;
            end
            4'd6: begin
                w.alu_op = ALU_SUB_P;
            end
            4'd7: begin
                w.alu_op   = ALU_ADD_D2;
                w.mul_en   = 1'b1;
                w.mul_coef = COEF_B2;
                w.mul_src  = MSRC_X;
            end
            4'd8: begin
                w.wr_d1    = 1'b1;
                w.alu_op   = ALU_LOAD_P;
                w.mul_en   = 1'b1;
                w.mul_coef = COEF_A2;
                w.mul_src  = MSRC_Y;
            end
            4'd9: begin
                w.alu_op = ALU_SUB_P;
            end
            4'd10: begin
                w.cond   = COND_JUMP_OUT_FREE;
                w.target = STEP_IDLE;
                w.wr_d2  = 1'b1;
                w.ld_out = 1'b1;
            end
            default: begin
                w.cond   = COND_JUMP_OUT_FREE;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    // Saturating add or subtract on the state width; the top bit flags a clip.
    function automatic logic [STATE_W:0] sat_add(
        input logic signed [STATE_W-1:0] a,
        input logic signed [STATE_W-1:0] b,
        input logic                      sub
    );
        logic [STATE_W:0] s;
        if (sub) begin
            s = {a[STATE_W-1], a} - {b[STATE_W-1], b};
        end else begin
            s = {a[STATE_W-1], a} + {b[STATE_W-1], b};
        end
        if (s[STATE_W] != s[STATE_W-1]) begin
            return {1'b1, (s[STATE_W] ? STATE_MIN : STATE_MAX)};
        end
        return {1'b0, s[STATE_W-1:0]};
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bqd_sequencer.sv
`default_nettype none

module bqd_sequencer
    import bqd_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  wire   i_out_free,
    output logic  o_in_ready,
    output t_ctrl o_ctrl,
    output t_step o_step
);

    t_step r_step;
    t_step n_step;
    t_ctrl w_word;
    logic  w_go;

    assign w_word = prog_rom(r_step);

    always_comb begin
        case (w_word.cond)
            COND_NEXT:          w_go = 1'b1;
            COND_WAIT_IN:       w_go = i_in_valid;
            COND_JUMP_OUT_FREE: w_go = i_out_free;
            default:            w_go = 1'b0;
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (w_go) begin
            if (w_word.cond == COND_JUMP_OUT_FREE) begin
                n_step = w_word.target;
            end else begin
                n_step = t_step'(r_step + 1'b1);
            end
        end
    end

    always_comb begin
        o_in_ready = (w_word.cond == COND_WAIT_IN);
        o_ctrl     = w_word;
        if (!w_go) begin
            o_ctrl.mul_en = 1'b0;
            o_ctrl.alu_op = ALU_NOP;
            o_ctrl.ld_x   = 1'b0;
            o_ctrl.wr_d1  = 1'b0;
            o_ctrl.wr_d2  = 1'b0;
            o_ctrl.ld_out = 1'b0;
        end
    end

    assign o_step = r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bqd_datapath.sv
`default_nettype none

module bqd_datapath
    import bqd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEFF_WIDTH  = 32
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire  t_ctrl             i_ctrl,
    input  wire  [SAMPLE_WIDTH-1:0] i_sample,
    input  wire                     i_cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [COEFF_WIDTH-1:0]  i_cfg_data,
    output logic [SAMPLE_WIDTH-1:0] o_y,
    output logic                    o_clip
);

    localparam int PROD_W    = COEFF_WIDTH + SAMPLE_WIDTH;
    localparam int OUT_SHIFT = COEFF_WIDTH - 4;
    localparam int NUM_COEF  = 5;

    localparam logic signed [STATE_W-1:0] RND_CONST = STATE_W'(1) << (OUT_SHIFT - 1);
    localparam logic signed [STATE_W-1:0] Y_MAX =
        (STATE_W'(1) << (SAMPLE_WIDTH - 1)) - STATE_W'(1);
    localparam logic signed [STATE_W-1:0] Y_MIN = -Y_MAX - STATE_W'(1);
    localparam logic [COEFF_WIDTH-1:0] UNITY = COEFF_WIDTH'(1) << OUT_SHIFT;

    logic signed [COEFF_WIDTH-1:0]  r_coef [NUM_COEF];
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [SAMPLE_WIDTH-1:0] r_y;
    logic signed [STATE_W-1:0]      r_prod;
    logic signed [STATE_W-1:0]      r_acc;
    logic signed [STATE_W-1:0]      r_d1;
    logic signed [STATE_W-1:0]      r_d2;
    logic                           r_clip;

    logic signed [STATE_W-1:0]      n_acc;
    logic signed [SAMPLE_WIDTH-1:0] n_y;
    logic                           n_clip;

    logic signed [COEFF_WIDTH-1:0]  w_coef;
    logic signed [SAMPLE_WIDTH-1:0] w_opnd;
    logic signed [PROD_W-1:0]       w_prod_full;
    logic signed [STATE_W-1:0]      w_prod;
    logic signed [STATE_W-1:0]      w_a;
    logic signed [STATE_W-1:0]      w_b;
    logic                           w_sub;
    logic [STATE_W:0]               w_sum;
    logic signed [STATE_W-1:0]      w_shifted;

    assign w_coef      = r_coef[i_ctrl.mul_coef];
    assign w_opnd      = (i_ctrl.mul_src == MSRC_Y) ? r_y : r_x;
    assign w_prod_full = w_coef * w_opnd;

    generate
        if (PROD_W >= STATE_W) begin : g_prod_wrap
            assign w_prod = w_prod_full[STATE_W-1:0];
        end else begin : g_prod_ext
            assign w_prod = {{(STATE_W-PROD_W){w_prod_full[PROD_W-1]}}, w_prod_full};
        end
    endgenerate

    always_comb begin
        w_a   = r_acc;
        w_b   = '0;
        w_sub = 1'b0;
        case (i_ctrl.alu_op)
            ALU_ADD_P_D1: begin
                w_a = r_prod;
                w_b = r_d1;
            end
            ALU_ADD_RND: w_b = RND_CONST;
            ALU_SUB_P: begin
                w_b   = r_prod;
                w_sub = 1'b1;
            end
            ALU_ADD_D2:  w_b = r_d2;
            default:     w_b = '0;
        endcase
    end

    assign w_sum     = sat_add(w_a, w_b, w_sub);
    assign w_shifted = r_acc >>> OUT_SHIFT;

    always_comb begin
        n_acc  = r_acc;
        n_y    = r_y;
        n_clip = r_clip;
        case (i_ctrl.alu_op)
            ALU_LOAD_P: n_acc = r_prod;
            ALU_ADD_P_D1, ALU_ADD_RND, ALU_SUB_P, ALU_ADD_D2: begin
                n_acc  = w_sum[STATE_W-1:0];
                n_clip = r_clip | w_sum[STATE_W];
            end
            ALU_FORM_Y: begin
                if (w_shifted > Y_MAX) begin
                    n_y    = Y_MAX[SAMPLE_WIDTH-1:0];
                    n_clip = 1'b1;
                end else if (w_shifted < Y_MIN) begin
                    n_y    = Y_MIN[SAMPLE_WIDTH-1:0];
                    n_clip = 1'b1;
                end else begin
                    n_y = w_shifted[SAMPLE_WIDTH-1:0];
                end
            end
            default: n_acc = r_acc;
        endcase
        if (i_ctrl.ld_x) begin
            n_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_y    <= n_y;
        r_clip <= n_clip;
        if (i_ctrl.ld_x) begin
            r_x <= i_sample;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[COEF_B0] <= UNITY;
            r_coef[COEF_B1] <= '0;
            r_coef[COEF_B2] <= '0;
            r_coef[COEF_A1] <= '0;
            r_coef[COEF_A2] <= '0;
            r_d1            <= '0;
            r_d2            <= '0;
        end else begin
            if (i_ctrl.wr_d1) begin
                r_d1 <= r_acc;
            end
            if (i_ctrl.wr_d2) begin
                r_d2 <= r_acc;
            end
            if (i_cfg_wr_en && (i_cfg_index inside {[COEF_B0:COEF_A2]})) begin
                r_coef[i_cfg_index] <= i_cfg_data;
                r_d1                <= '0;
                r_d2                <= '0;
            end
        end
    end

    assign o_y    = r_y;
    assign o_clip = r_clip;

endmodule

`default_nettype wire

FILE: hdl/biquad_iir_filter_unit.sv
`default_nettype none

// Each sample runs through the 11-step microprogram that shares a single
// multiplier and a single saturating adder; no new sample is taken before the
// program is back at step 0, and the last step waits while the output register
// is still held by a stalled downstream side.
// Reset (synchronous, active low) clears both delay states, sets b0 to 1.0 and
// the other coefficients to zero, and empties the output register.
module biquad_iir_filter_unit
    import bqd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEFF_WIDTH  = 32
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // sample_in
    input  wire  [((SAMPLE_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    // sample_out
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // clipped
    output logic                              o_m_axis_tuser,
    input  wire                               i_cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0]              i_cfg_index,
    input  wire  [COEFF_WIDTH-1:0]            i_cfg_data
);

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    t_ctrl                   w_ctrl;
    t_step                   w_step;
    logic                    w_out_free;
    logic [SAMPLE_WIDTH-1:0] w_y;
    logic                    w_clip;

    logic                    r_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_out_sample;
    logic                    r_out_clip;

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    bqd_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_out_free (w_out_free),
        .o_in_ready (o_s_axis_tready),
        .o_ctrl     (w_ctrl),
        .o_step     (w_step)
    );

    bqd_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEFF_WIDTH  (COEFF_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_sample    (i_s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_y         (w_y),
        .o_clip      (w_clip)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.ld_out) begin
            r_out_sample <= w_y;
            r_out_clip   <= w_clip;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'(r_out_sample);
    assign o_m_axis_tuser  = r_out_clip;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (!o_s_axis_tready && w_step != STEP_IDLE))
        else $error("sequencer took a new sample while busy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.ld_out |-> (!r_out_valid || i_m_axis_tready))
        else $error("result register overwritten before it was taken");

    a_valid_from_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_ctrl.ld_out))
        else $error("output valid rose without a result from the microprogram");
`endif

endmodule

`default_nettype wire
